>>> rtl/eralu_pkg.sv
// Package: operation codes, flag bit positions, sizes, states and iterative-unit types for the eight-register ALU.
`default_nettype none
package eralu_pkg;
    localparam int MEM_WORDS = 65536;
    localparam int MEM_AW = $clog2(MEM_WORDS);

    typedef enum logic [2:0] {
        OP_FETCH = 3'd0,
        OP_STORE = 3'd1,
        OP_ADD   = 3'd2,
        OP_SUB   = 3'd3,
        OP_MUL   = 3'd4,
        OP_DIV   = 3'd5,
        OP_MOD   = 3'd6,
        OP_LEAQ  = 3'd7
    } op_t;

    localparam int FLAG_ZERO  = 0;
    localparam int FLAG_SIGN  = 1;
    localparam int FLAG_CARRY = 2;
    localparam int FLAG_OVF   = 3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_OPS,
        ST_ITER,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic        start;
        logic        is_div;
        logic [31:0] a;
        logic [31:0] b;
    } iter_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] prod;
        logic [31:0] quot;
        logic [31:0] rem;
    } iter_rsp_t;
endpackage
`default_nettype wire

>>> rtl/eralu_iter.sv
// Shared shift-add multiplier and shift-subtract divider, one bit per cycle.
`default_nettype none
module eralu_iter
    import eralu_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  iter_req_t      req,
    output iter_rsp_t      rsp
);
    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  count_reg;
    logic        div_reg;
    logic [31:0] a_reg;
    logic [31:0] b_reg;
    logic [31:0] acc_reg;
    logic [31:0] q_reg;
    logic [33:0] trial;
    logic [32:0] rem_shift;

    assign rem_shift = {acc_reg, q_reg[31]};
    assign trial = {1'b0, rem_shift} - {2'b00, b_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= 6'd32;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - 6'd1;
                if (count_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            div_reg <= req.is_div;
            a_reg   <= req.a;
            b_reg   <= req.b;
            acc_reg <= '0;
            q_reg   <= req.a;
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                if (!trial[33])
                    acc_reg <= trial[31:0];
                else
                    acc_reg <= rem_shift[31:0];
                q_reg <= {q_reg[30:0], ~trial[33]};
            end
            else
            begin
                acc_reg <= (b_reg[0] ? acc_reg + a_reg : acc_reg);
                a_reg   <= {a_reg[30:0], 1'b0};
                b_reg   <= {1'b0, b_reg[31:1]};
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;
    assign rsp.quot = (b_reg == '0) ? '0 : q_reg;
    assign rsp.rem  = (b_reg == '0) ? '0 : acc_reg;
endmodule
`default_nettype wire

>>> rtl/eight_register_alu_with_flags.sv
// Eight-register ALU with flags: control, register file, word memory and result strobe.
// Fetch, store, add, sub and leaq step through the read, operate and done states to valid;
// mul, div and mod also wait in the iterate state on the 32-step one-bit-per-cycle unit.
// One instruction at a time: busy drops with valid, and the next start can be taken while
// valid is high. The valid strobe cannot be stalled.
// Reset clears registers, flags and holding registers; memory is undefined until written.
`default_nettype none
module eight_register_alu_with_flags
    import eralu_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [2:0]         func,
    input  wire logic [2:0]         first_reg,
    input  wire logic [2:0]         second_reg,
    input  wire logic [2:0]         third_reg,
    input  wire logic [17:0]        address,
    input  wire logic signed [31:0] displacement,
    input  wire logic [7:0]         scale,
    output logic                    valid,
    output logic [2:0]              dest_index,
    output logic                    dest_written,
    output logic signed [31:0]      dest_value,
    output logic [3:0]              flag_bits,
    output logic [17:0]             mem_addr_hold,
    output logic signed [31:0]      mem_data_hold
);
    state_t      state_reg, state_next;
    op_t         op_reg;
    logic [2:0]  ra_reg, rb_reg, rc_reg;
    logic [17:0] addr_reg;
    logic [31:0] disp_reg;
    logic [7:0]  scale_reg;
    logic [7:0]  rf_valid_reg;
    logic [31:0] rf_mem [8];
    logic [31:0] rf_a_reg, rf_b_reg;
    logic [31:0] word_mem [MEM_WORDS];
    logic [31:0] mem_rd_reg;
    logic [31:0] a_val, b_val;
    logic [31:0] sb_reg;
    logic [31:0] res;
    logic [3:0]  flags_reg, flags_next;
    logic [2:0]  dest;
    logic        wr;
    logic [32:0] sum;
    logic [31:0] nb;
    logic [MEM_AW-1:0] widx;
    iter_req_t   req;
    iter_rsp_t   rsp;

    eralu_iter u_iter (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    assign busy = (state_reg != ST_IDLE);
    assign widx = addr_reg[MEM_AW+1:2];
    assign a_val = rf_valid_reg[ra_reg] ? rf_a_reg : '0;
    assign b_val = rf_valid_reg[rb_reg] ? rf_b_reg : '0;
    assign nb = '0 - b_val;

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            op_reg    <= op_t'(func);
            ra_reg    <= first_reg;
            rb_reg    <= second_reg;
            rc_reg    <= third_reg;
            addr_reg  <= address;
            disp_reg  <= displacement;
            scale_reg <= scale;
        end
        if (state_reg == ST_READ)
        begin
            rf_a_reg   <= rf_mem[ra_reg];
            rf_b_reg   <= rf_mem[rb_reg];
            mem_rd_reg <= word_mem[widx];
        end
        if (state_reg == ST_OPS)
        begin
            sb_reg <= {24'd0, scale_reg} * b_val;
            if (op_reg == OP_STORE)
                word_mem[widx] <= a_val;
        end
        if (state_reg == ST_DONE && wr)
            rf_mem[dest] <= res;
    end

    always_comb
    begin
        dest = rb_reg;
        wr = 1'b1;
        res = '0;
        flags_next = flags_reg;
        sum = '0;
        case (op_reg)
            OP_FETCH:
            begin
                res = mem_rd_reg;
                dest = ra_reg;
            end
            OP_STORE:
            begin
                res = a_val;
                dest = '0;
                wr = 1'b0;
            end
            OP_ADD:
            begin
                sum = {1'b0, a_val} + {1'b0, b_val};
                res = sum[31:0];
                flags_next[FLAG_CARRY] = (a_val[31] & b_val[31]) | (a_val[31] & ~res[31])
                    | (b_val[31] & ~res[31]);
                flags_next[FLAG_OVF] = (a_val[31] == b_val[31]) && (res[31] != a_val[31]);
            end
            OP_SUB:
            begin
                res = a_val + nb;
                flags_next[FLAG_CARRY] = (a_val[31] & nb[31]) | (a_val[31] & ~res[31])
                    | (nb[31] & ~res[31]);
                flags_next[FLAG_OVF] = (a_val[31] != nb[31]) && (res[31] == nb[31]);
            end
            OP_MUL: res = rsp.prod;
            OP_DIV: res = rsp.quot;
            OP_MOD: res = rsp.rem;
            OP_LEAQ:
            begin
                res = disp_reg + a_val + sb_reg;
                dest = rc_reg;
            end
            default: res = '0;
        endcase
        if (op_reg != OP_FETCH && op_reg != OP_STORE && op_reg != OP_LEAQ)
        begin
            flags_next[FLAG_ZERO] = (res == '0);
            flags_next[FLAG_SIGN] = res[31];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req.start = 1'b0;
        req.is_div = (op_reg == OP_DIV) || (op_reg == OP_MOD);
        req.a = a_val;
        req.b = b_val;
        case (state_reg)
            ST_IDLE: if (start) state_next = ST_READ;
            ST_READ: state_next = ST_OPS;
            ST_OPS:
            begin
                if (op_reg == OP_MUL || op_reg == OP_DIV || op_reg == OP_MOD)
                begin
                    req.start = 1'b1;
                    state_next = ST_ITER;
                end
                else
                    state_next = ST_DONE;
            end
            ST_ITER: if (rsp.done) state_next = ST_DONE;
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rf_valid_reg  <= '0;
            flags_reg     <= '0;
            mem_addr_hold <= '0;
            mem_data_hold <= '0;
            valid         <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid <= 1'b0;
            if (state_reg == ST_DONE)
            begin
                valid <= 1'b1;
                flags_reg <= flags_next;
                if (wr)
                    rf_valid_reg[dest] <= 1'b1;
                if (op_reg == OP_FETCH || op_reg == OP_STORE)
                begin
                    mem_addr_hold <= addr_reg;
                    mem_data_hold <= res;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE)
        begin
            dest_index   <= dest;
            dest_written <= wr;
            dest_value   <= res;
        end
    end

    assign flag_bits = flags_reg;
endmodule
`default_nettype wire

>>> tb/eight_register_alu_with_flags_test.sv
// Self-checking testbench: directed and random instructions with a predictor of the ALU state.
`default_nettype none
module eight_register_alu_with_flags_test;
    import eralu_pkg::*;

    typedef struct packed {
        op_t         op;
        logic [2:0]  ra;
        logic [2:0]  rb;
        logic [2:0]  rc;
        logic [17:0] addr;
        logic [31:0] disp;
        logic [7:0]  scale;
    } instr_t;

    typedef struct packed {
        logic [2:0]  dest;
        logic        written;
        logic [31:0] value;
        logic [3:0]  flags;
        logic [17:0] addr_hold;
        logic [31:0] data_hold;
    } outcome_t;

    localparam int RANDOM_INSTRS = 1130;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 40;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         func;
    logic [2:0]         first_reg;
    logic [2:0]         second_reg;
    logic [2:0]         third_reg;
    logic [17:0]        address;
    logic signed [31:0] displacement;
    logic [7:0]         scale;
    logic               valid;
    logic [2:0]         dest_index;
    logic               dest_written;
    logic signed [31:0] dest_value;
    logic [3:0]         flag_bits;
    logic [17:0]        mem_addr_hold;
    logic signed [31:0] mem_data_hold;

    logic [31:0] regs_model [8];
    logic [3:0]  flags_model;
    logic [17:0] addr_hold_model;
    logic [31:0] data_hold_model;
    logic [31:0] mem_model [int];
    int          stored_words[$];

    outcome_t    pending_outcomes[$];
    instr_t      directed_instrs[$];
    outcome_t    directed_typed[$];
    bit          directed_has_typed[$];
    int          error_count;
    int          quiet_cycles;

    eight_register_alu_with_flags uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .func(func), .first_reg(first_reg), .second_reg(second_reg),
        .third_reg(third_reg), .address(address), .displacement(displacement),
        .scale(scale), .valid(valid), .dest_index(dest_index),
        .dest_written(dest_written), .dest_value(dest_value), .flag_bits(flag_bits),
        .mem_addr_hold(mem_addr_hold), .mem_data_hold(mem_data_hold)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void set_zero_sign(input logic [31:0] r);
        flags_model[FLAG_ZERO] = (r == 32'd0);
        flags_model[FLAG_SIGN] = r[31];
    endfunction

    function automatic outcome_t execute_instr(input instr_t ins);
        outcome_t    res;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] nb;
        logic [32:0] wide;
        int          word;
        a = regs_model[ins.ra];
        b = regs_model[ins.rb];
        word = int'(ins.addr[17:2]);
        res.dest = ins.rb;
        res.written = 1'b1;
        res.value = 32'd0;
        case (ins.op)
            OP_FETCH:
            begin
                res.value = mem_model[word];
                res.dest = ins.ra;
                addr_hold_model = ins.addr;
                data_hold_model = res.value;
            end
            OP_STORE:
            begin
                if (!mem_model.exists(word))
                    stored_words.push_back(word);
                mem_model[word] = a;
                res.value = a;
                res.dest = 3'd0;
                res.written = 1'b0;
                addr_hold_model = ins.addr;
                data_hold_model = a;
            end
            OP_ADD:
            begin
                wide = {1'b0, a} + {1'b0, b};
                res.value = wide[31:0];
                set_zero_sign(res.value);
                flags_model[FLAG_CARRY] = wide[32];
                flags_model[FLAG_OVF] = (a[31] == b[31]) && (res.value[31] != a[31]);
            end
            OP_SUB:
            begin
                nb = 32'd0 - b;
                wide = {1'b0, a} + {1'b0, nb};
                res.value = wide[31:0];
                set_zero_sign(res.value);
                flags_model[FLAG_CARRY] = wide[32];
                flags_model[FLAG_OVF] = (a[31] != nb[31]) && (res.value[31] == nb[31]);
            end
            OP_MUL:
            begin
                res.value = a * b;
                set_zero_sign(res.value);
            end
            OP_DIV:
            begin
                res.value = (b == 32'd0) ? 32'd0 : a / b;
                set_zero_sign(res.value);
            end
            OP_MOD:
            begin
                res.value = (b == 32'd0) ? 32'd0 : a % b;
                set_zero_sign(res.value);
            end
            default:
            begin
                res.value = ins.disp + a + {24'd0, ins.scale} * b;
                res.dest = ins.rc;
            end
        endcase
        if (res.written)
            regs_model[res.dest] = res.value;
        res.flags = flags_model;
        res.addr_hold = addr_hold_model;
        res.data_hold = data_hold_model;
        return res;
    endfunction

    function automatic instr_t make_instr(input op_t op, input logic [2:0] ra,
                                          input logic [2:0] rb, input logic [2:0] rc,
                                          input logic [17:0] addr, input logic [31:0] disp,
                                          input logic [7:0] sc);
        instr_t ins;
        ins.op = op;
        ins.ra = ra;
        ins.rb = rb;
        ins.rc = rc;
        ins.addr = addr;
        ins.disp = disp;
        ins.scale = sc;
        return ins;
    endfunction

    function automatic void add_row(input instr_t ins, input bit typed, input outcome_t res);
        directed_instrs.push_back(ins);
        directed_has_typed.push_back(typed);
        directed_typed.push_back(res);
    endfunction

    function automatic instr_t random_instr();
        instr_t ins;
        int     pick;
        ins.ra = 3'($urandom);
        ins.rb = 3'($urandom);
        ins.rc = 3'($urandom);
        ins.addr = 18'($urandom);
        ins.disp = $urandom;
        ins.scale = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            ins.op = OP_LEAQ;
            if ($urandom_range(0, 3) == 0)
            begin
                ins.disp = $urandom_range(0, 15);
                ins.scale = 8'd0;
            end
        end
        else if (pick < 30)
            ins.op = OP_STORE;
        else if (pick < 42)
            ins.op = OP_FETCH;
        else
            ins.op = op_t'($urandom_range(OP_ADD, OP_MOD));
        if (ins.op == OP_FETCH)
        begin
            if (stored_words.size() == 0)
                ins.op = OP_STORE;
            else
                ins.addr = {16'(stored_words[$urandom_range(0, stored_words.size() - 1)]),
                            2'($urandom)};
        end
        return ins;
    endfunction

    task automatic send_beat(input instr_t ins, input bit typed, input outcome_t res);
        outcome_t predicted;
        start <= 1'b1;
        func <= ins.op;
        first_reg <= ins.ra;
        second_reg <= ins.rb;
        third_reg <= ins.rc;
        address <= ins.addr;
        displacement <= ins.disp;
        scale <= ins.scale;
        do
            @(posedge clk);
        while (busy);
        predicted = execute_instr(ins);
        pending_outcomes.push_back(typed ? res : predicted);
    endtask

    task automatic hold_off(input int n);
        if ($urandom_range(0, 99) < 28 && (n < 400 || n > 650))
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < 60);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (valid || (start && !busy))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && valid)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $error("unexpected beat: dest_value %h", dest_value);
                error_count++;
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (dest_index !== want.dest)
                begin
                    $error("dest_index expected %0d actual %0d", want.dest, dest_index);
                    error_count++;
                end
                if (dest_written !== want.written)
                begin
                    $error("dest_written expected %0d actual %0d", want.written, dest_written);
                    error_count++;
                end
                if (dest_value !== want.value)
                begin
                    $error("dest_value expected %h actual %h", want.value, dest_value);
                    error_count++;
                end
                if (flag_bits !== want.flags)
                begin
                    $error("flag_bits expected %b actual %b", want.flags, flag_bits);
                    error_count++;
                end
                if (mem_addr_hold !== want.addr_hold)
                begin
                    $error("mem_addr_hold expected %h actual %h", want.addr_hold, mem_addr_hold);
                    error_count++;
                end
                if (mem_data_hold !== want.data_hold)
                begin
                    $error("mem_data_hold expected %h actual %h", want.data_hold, mem_data_hold);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        outcome_t none;
        none = '0;
        error_count = 0;
        quiet_cycles = 0;
        rst_n = 1'b0;
        start = 1'b0;
        func = OP_FETCH;
        first_reg = 3'd0;
        second_reg = 3'd0;
        third_reg = 3'd0;
        address = 18'd0;
        displacement = 32'sd0;
        scale = 8'd0;
        for (int r = 0; r < 8; r++)
            regs_model[r] = 32'd0;
        flags_model = 4'd0;
        addr_hold_model = 18'd0;
        data_hold_model = 32'd0;

        add_row(make_instr(OP_ADD, 3'd0, 3'd1, 3'd0, 18'd0, 32'd0, 8'd0), 1,
                '{3'd1, 1'b1, 32'd0, 4'b0001, 18'd0, 32'd0});
        add_row(make_instr(OP_DIV, 3'd0, 3'd1, 3'd0, 18'd0, 32'd0, 8'd0), 1,
                '{3'd1, 1'b1, 32'd0, 4'b0001, 18'd0, 32'd0});
        add_row(make_instr(OP_MOD, 3'd0, 3'd2, 3'd0, 18'd0, 32'd0, 8'd0), 1,
                '{3'd2, 1'b1, 32'd0, 4'b0001, 18'd0, 32'd0});
        add_row(make_instr(OP_LEAQ, 3'd0, 3'd0, 3'd3, 18'd0, 32'h7FFF_FFFF, 8'hFF), 1,
                '{3'd3, 1'b1, 32'h7FFF_FFFF, 4'b0001, 18'd0, 32'd0});
        add_row(make_instr(OP_LEAQ, 3'd0, 3'd0, 3'd4, 18'd0, 32'h8000_0000, 8'd0), 1,
                '{3'd4, 1'b1, 32'h8000_0000, 4'b0001, 18'd0, 32'd0});
        add_row(make_instr(OP_LEAQ, 3'd0, 3'd0, 3'd5, 18'd0, 32'hFFFF_FFFF, 8'd0), 1,
                '{3'd5, 1'b1, 32'hFFFF_FFFF, 4'b0001, 18'd0, 32'd0});
        add_row(make_instr(OP_STORE, 3'd5, 3'd0, 3'd0, 18'h3FFFF, 32'd0, 8'd0), 1,
                '{3'd0, 1'b0, 32'hFFFF_FFFF, 4'b0001, 18'h3FFFF, 32'hFFFF_FFFF});
        add_row(make_instr(OP_STORE, 3'd3, 3'd0, 3'd0, 18'd0, 32'd0, 8'd0), 1,
                '{3'd0, 1'b0, 32'h7FFF_FFFF, 4'b0001, 18'd0, 32'h7FFF_FFFF});
        add_row(make_instr(OP_FETCH, 3'd6, 3'd0, 3'd0, 18'd0, 32'd0, 8'd0), 1,
                '{3'd6, 1'b1, 32'h7FFF_FFFF, 4'b0001, 18'd0, 32'h7FFF_FFFF});
        add_row(make_instr(OP_FETCH, 3'd7, 3'd0, 3'd0, 18'h3FFFF, 32'd0, 8'd0), 1,
                '{3'd7, 1'b1, 32'hFFFF_FFFF, 4'b0001, 18'h3FFFF, 32'hFFFF_FFFF});
        add_row(make_instr(OP_ADD, 3'd3, 3'd3, 3'd0, 18'd0, 32'd0, 8'd0), 0, none);
        add_row(make_instr(OP_ADD, 3'd5, 3'd7, 3'd0, 18'd0, 32'd0, 8'd0), 0, none);
        add_row(make_instr(OP_SUB, 3'd4, 3'd6, 3'd0, 18'd0, 32'd0, 8'd0), 0, none);
        add_row(make_instr(OP_SUB, 3'd0, 3'd4, 3'd0, 18'd0, 32'd0, 8'd0), 0, none);
        add_row(make_instr(OP_SUB, 3'd6, 3'd6, 3'd0, 18'd0, 32'd0, 8'd0), 0, none);
        add_row(make_instr(OP_LEAQ, 3'd5, 3'd5, 3'd1, 18'd0, 32'h0000_0010, 8'hFF), 0, none);
        add_row(make_instr(OP_MUL, 3'd5, 3'd5, 3'd0, 18'd0, 32'd0, 8'd0), 0, none);
        add_row(make_instr(OP_MUL, 3'd1, 3'd1, 3'd0, 18'd0, 32'd0, 8'd0), 0, none);
        add_row(make_instr(OP_LEAQ, 3'd0, 3'd0, 3'd2, 18'd0, 32'hFFFF_FFFF, 8'd0), 0, none);
        add_row(make_instr(OP_DIV, 3'd2, 3'd2, 3'd0, 18'd0, 32'd0, 8'd0), 0, none);
        add_row(make_instr(OP_LEAQ, 3'd0, 3'd0, 3'd4, 18'd0, 32'd7, 8'd0), 0, none);
        add_row(make_instr(OP_MOD, 3'd7, 3'd4, 3'd0, 18'd0, 32'd0, 8'd0), 0, none);
        add_row(make_instr(OP_DIV, 3'd7, 3'd4, 3'd0, 18'd0, 32'd0, 8'd0), 0, none);
        add_row(make_instr(OP_ADD, 3'd0, 3'd0, 3'd0, 18'd0, 32'd0, 8'd0), 0, none);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int n = 0; n < directed_instrs.size(); n++)
        begin
            hold_off(0);
            send_beat(directed_instrs[n], directed_has_typed[n], directed_typed[n]);
        end
        for (int n = 0; n < RANDOM_INSTRS; n++)
        begin
            if (n == 700)
            begin
                start <= 1'b0;
                while (pending_outcomes.size() != 0)
                    @(posedge clk);
                @(posedge clk);
            end
            hold_off(n);
            send_beat(random_instr(), 0, none);
        end
        start <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire
